/* src/dtpy_pkg.sv */
// Shared types and constants for the direction to pitch and yaw converter.
// Holds the arctangent table, the CORDIC gain and the angle formats.
// Depends on nothing.
package dtpy_pkg;

  localparam int unsigned GUARD_BITS = 16;
  localparam int unsigned ANG_Q      = 24;
  localparam int unsigned ANG_W      = 35;
  localparam int unsigned GAIN_SHIFT = 30 - GUARD_BITS;

  localparam logic signed [31:0] GAIN_Q30 = 32'sd1768195363;

  localparam int unsigned DEG_90  = 90;
  localparam int unsigned DEG_180 = 180;
  localparam int unsigned DEG_270 = 270;
  localparam int unsigned DEG_360 = 360;

  localparam logic [29:0] ATAN_Q24 [32] = '{
    30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
    30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
    30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
    30'd234684,    30'd117342,    30'd58671,     30'd29335,
    30'd14668,     30'd7334,      30'd3667,      30'd1833,
    30'd917,       30'd458,       30'd229,       30'd115,
    30'd57,        30'd29,        30'd14,        30'd7,
    30'd4,         30'd2,         30'd1,         30'd0
  };

  typedef struct packed {
    logic valid;
    logic zero_hor;
    logic z_pos;
  } dtpy_ctrl_t;

endpackage

/* src/dtpy_cordic_stage.sv */
// One registered vectoring step of the CORDIC pipeline.
// Uses the arctangent table and control type from dtpy_pkg.
module dtpy_cordic_stage
  import dtpy_pkg::*;
#(
  parameter int W      = 45,
  parameter int AW     = 35,
  parameter int SIDE_W = 1,
  parameter int SHIFT  = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dtpy_ctrl_t               ctrl_i,
  input  logic signed [W-1:0]      x_i,
  input  logic signed [W-1:0]      y_i,
  input  logic signed [AW-1:0]     ang_i,
  input  logic        [SIDE_W-1:0] side_i,
  output dtpy_ctrl_t               ctrl_o,
  output logic signed [W-1:0]      x_o,
  output logic signed [W-1:0]      y_o,
  output logic signed [AW-1:0]     ang_o,
  output logic        [SIDE_W-1:0] side_o
);

  localparam logic signed [AW-1:0] STEP_ANG = AW'(ATAN_Q24[SHIFT]);

  dtpy_ctrl_t               ctrl_q;
  logic signed [W-1:0]      x_d, x_q, y_d, y_q, dx, dy;
  logic signed [AW-1:0]     ang_d, ang_q;
  logic        [SIDE_W-1:0] side_q;

  always_comb begin
    dx = y_i >>> SHIFT;
    dy = x_i >>> SHIFT;
    if (y_i > 0) begin
      x_d   = x_i + dx;
      y_d   = y_i - dy;
      ang_d = ang_i + STEP_ANG;
    end else begin
      x_d   = x_i - dx;
      y_d   = y_i + dy;
      ang_d = ang_i - STEP_ANG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    ang_q  <= ang_d;
    side_q <= side_i;
  end

  assign ctrl_o = ctrl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign ang_o  = ang_q;
  assign side_o = side_q;

endmodule

/* src/dtpy_angle_out.sv */
// Converts a signed Q24 degree angle into the wrapped, rounded output format.
// Uses the angle constants from dtpy_pkg.
module dtpy_angle_out
  import dtpy_pkg::*;
#(
  parameter int AW   = 35,
  parameter int FRAC = 7
) (
  input  logic signed [AW-1:0] ang_i,
  output logic        [15:0]   angle_o
);

  localparam int SH = ANG_Q - FRAC;
  localparam int RW = AW - SH;
  localparam logic signed [AW-1:0] TURN_Q  = AW'(64'(DEG_360) << ANG_Q);
  localparam logic        [AW-1:0] HALF_Q  = AW'(64'(1) << (SH - 1));
  localparam logic        [RW-1:0] TURN_OUT = RW'(64'(DEG_360) << FRAC);

  logic signed [AW-1:0] wrapped;
  logic        [AW-1:0] rounded;
  logic        [RW-1:0] coarse, folded;

  always_comb begin
    wrapped = (ang_i < 0) ? ang_i + TURN_Q : ang_i;
    if (wrapped < 0) begin
      wrapped = '0;
    end
    rounded = $unsigned(wrapped) + HALF_Q;
    coarse  = rounded[AW-1:SH];
    folded  = (coarse >= TURN_OUT) ? coarse - TURN_OUT : coarse;
    angle_o = folded[15:0];
  end

endmodule

/* src/direction_to_pitch_yaw.sv */
// Direction to pitch and yaw converter: a fully pipelined pair of CORDIC
// vectoring units. Uses dtpy_pkg, dtpy_cordic_stage and dtpy_angle_out.
//
// A new direction request may be issued on every clock cycle and busy_o is
// never raised. Each request yields exactly one result, shown on the result
// ports for one cycle with done_o high. The request passes through an input
// register for the scaling and gain multiplication, one register per step in
// each of the yaw and pitch CORDIC chains, and an output register after
// rounding. The receiver has no means of stalling, so results must be taken
// as they appear.
module direction_to_pitch_yaw
  import dtpy_pkg::*;
#(
  parameter int COORD_BITS      = 24,
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STEPS    = 18
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [COORD_BITS-1:0] dir_x_i,
  input  logic signed [COORD_BITS-1:0] dir_y_i,
  input  logic signed [COORD_BITS-1:0] dir_z_i,
  output logic                         done_o,
  output logic        [15:0]           pitch_angle_o,
  output logic        [15:0]           yaw_angle_o
);

  localparam int W  = COORD_BITS + GUARD_BITS + 5;
  localparam int PW = COORD_BITS + 32;
  localparam logic signed [ANG_W-1:0] HALF_TURN_Q = ANG_W'(64'(DEG_180) << ANG_Q);
  localparam logic [15:0] PITCH_UP   = 16'(64'(DEG_90) << ANGLE_FRAC_BITS);
  localparam logic [15:0] PITCH_DOWN = 16'(64'(DEG_270) << ANGLE_FRAC_BITS);

  logic signed [W-1:0]     x_sc, y_sc, x_d, y_d, x_q, y_q, mz_q;
  logic signed [PW-1:0]    z_prod;
  logic signed [ANG_W-1:0] ang_d, ang_q;
  dtpy_ctrl_t              ctrl_d, ctrl_q;

  assign busy_o = 1'b0;

  always_comb begin
    x_sc   = W'(dir_x_i) <<< GUARD_BITS;
    y_sc   = W'(dir_y_i) <<< GUARD_BITS;
    z_prod = PW'(dir_z_i) * PW'(GAIN_Q30);
    if (dir_x_i < 0) begin
      x_d   = -x_sc;
      y_d   = -y_sc;
      ang_d = HALF_TURN_Q;
    end else begin
      x_d   = x_sc;
      y_d   = y_sc;
      ang_d = '0;
    end
    ctrl_d.valid    = start_i;
    ctrl_d.zero_hor = (dir_x_i == '0) && (dir_y_i == '0);
    ctrl_d.z_pos    = (dir_z_i > 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    ang_q <= ang_d;
    mz_q  <= W'(z_prod >>> GAIN_SHIFT);
  end

  dtpy_ctrl_t              yctrl [0:CORDIC_STEPS];
  logic signed [W-1:0]     yx    [0:CORDIC_STEPS];
  logic signed [W-1:0]     yy    [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] yang  [0:CORDIC_STEPS];
  logic        [W-1:0]     yside [0:CORDIC_STEPS];

  dtpy_ctrl_t              pctrl [0:CORDIC_STEPS];
  logic signed [W-1:0]     px    [0:CORDIC_STEPS];
  logic signed [W-1:0]     py    [0:CORDIC_STEPS];
  logic signed [ANG_W-1:0] pang  [0:CORDIC_STEPS];
  logic        [ANG_W-1:0] pside [0:CORDIC_STEPS];

  assign yctrl[0] = ctrl_q;
  assign yx[0]    = x_q;
  assign yy[0]    = y_q;
  assign yang[0]  = ang_q;
  assign yside[0] = mz_q;

  assign pctrl[0] = yctrl[CORDIC_STEPS];
  assign px[0]    = yx[CORDIC_STEPS];
  assign py[0]    = $signed(yside[CORDIC_STEPS]);
  assign pang[0]  = '0;
  assign pside[0] = yang[CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    dtpy_cordic_stage #(
      .W      (W),
      .AW     (ANG_W),
      .SIDE_W (W),
      .SHIFT  (i)
    ) u_yaw (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (yctrl[i]),
      .x_i    (yx[i]),
      .y_i    (yy[i]),
      .ang_i  (yang[i]),
      .side_i (yside[i]),
      .ctrl_o (yctrl[i+1]),
      .x_o    (yx[i+1]),
      .y_o    (yy[i+1]),
      .ang_o  (yang[i+1]),
      .side_o (yside[i+1])
    );

    dtpy_cordic_stage #(
      .W      (W),
      .AW     (ANG_W),
      .SIDE_W (ANG_W),
      .SHIFT  (i)
    ) u_pitch (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (pctrl[i]),
      .x_i    (px[i]),
      .y_i    (py[i]),
      .ang_i  (pang[i]),
      .side_i (pside[i]),
      .ctrl_o (pctrl[i+1]),
      .x_o    (px[i+1]),
      .y_o    (py[i+1]),
      .ang_o  (pang[i+1]),
      .side_o (pside[i+1])
    );
  end

  logic [15:0] pitch_cvt, yaw_cvt;

  dtpy_angle_out #(
    .AW   (ANG_W),
    .FRAC (ANGLE_FRAC_BITS)
  ) u_pitch_out (
    .ang_i   (pang[CORDIC_STEPS]),
    .angle_o (pitch_cvt)
  );

  dtpy_angle_out #(
    .AW   (ANG_W),
    .FRAC (ANGLE_FRAC_BITS)
  ) u_yaw_out (
    .ang_i   ($signed(pside[CORDIC_STEPS])),
    .angle_o (yaw_cvt)
  );

  dtpy_ctrl_t  fin;
  logic        done_q;
  logic [15:0] pitch_d, pitch_q, yaw_d, yaw_q;

  always_comb begin
    fin = pctrl[CORDIC_STEPS];
    if (fin.zero_hor) begin
      pitch_d = fin.z_pos ? PITCH_UP : PITCH_DOWN;
      yaw_d   = '0;
    end else begin
      pitch_d = pitch_cvt;
      yaw_d   = yaw_cvt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    pitch_q <= pitch_d;
    yaw_q   <= yaw_d;
  end

  assign done_o        = done_q;
  assign pitch_angle_o = pitch_q;
  assign yaw_angle_o   = yaw_q;

endmodule

/* src/dtpy_checker.sv */
// Port-level checks for the direction to pitch and yaw converter.
// Attached to direction_to_pitch_yaw by the bind statement at the end.
module dtpy_checker #(
  parameter int COORD_BITS      = 24,
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STEPS    = 18
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic signed [COORD_BITS-1:0] dir_x_i,
  input logic signed [COORD_BITS-1:0] dir_y_i,
  input logic                         done_o,
  input logic        [15:0]           pitch_angle_o,
  input logic        [15:0]           yaw_angle_o
);

  localparam int LAT = 2 * CORDIC_STEPS + 2;
  localparam longint FULL = longint'(360) << ANGLE_FRAC_BITS;

  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy raised on a fully pipelined block");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("request did not yield a result after the pipeline latency");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LAT))
    else $error("result without a matching request");

  a_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (FULL > 65535) ||
               ((longint'(pitch_angle_o) < FULL) && (longint'(yaw_angle_o) < FULL)))
    else $error("angle outside one full turn");

  a_zero_yaw : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (dir_x_i == '0) && (dir_y_i == '0))
      |-> ##LAT (yaw_angle_o == '0))
    else $error("vertical direction gave a non-zero yaw");

endmodule

bind direction_to_pitch_yaw dtpy_checker #(
  .COORD_BITS      (COORD_BITS),
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
  .CORDIC_STEPS    (CORDIC_STEPS)
) u_dtpy_checker (.*);

/* bench/direction_to_pitch_yaw_tb.sv */
// Self-checking bench for direction_to_pitch_yaw: a queue-fed request driver, a
// result monitor and a bit-exact CORDIC angle predictor. Needs the block with its
// submodules and dtpy_pkg, which the block imports.
`timescale 1ns / 100ps

module direction_to_pitch_yaw_tb;

  localparam int COORD_BITS      = 24;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int CORDIC_STEPS    = 18;
  localparam int GUARD_SHIFT     = 16;
  localparam int GAIN_SHIFT      = 30 - GUARD_SHIFT;
  localparam int ANGLE_Q         = 24;
  localparam int ROUND_SHIFT     = ANGLE_Q - ANGLE_FRAC_BITS;
  localparam int PIPE_LATENCY    = 2 * CORDIC_STEPS + 2;
  localparam longint GAIN_Q30    = 64'sd1768195363;
  localparam longint FULL_TURN   = 64'sd360 <<< ANGLE_FRAC_BITS;
  localparam logic [15:0] PITCH_UP   = 16'(90 << ANGLE_FRAC_BITS);
  localparam logic [15:0] PITCH_DOWN = 16'(270 << ANGLE_FRAC_BITS);
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  localparam longint ARCTAN_Q24 [18] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334
  };

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    bit     drain_first;
  } direction_t;

  typedef struct {
    coord_t      x;
    coord_t      y;
    coord_t      z;
    logic [15:0] pitch;
    logic [15:0] yaw;
  } angles_t;

  typedef struct {
    longint mag;
    longint ang;
  } rotation_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  coord_t      dir_x_i = '0;
  coord_t      dir_y_i = '0;
  coord_t      dir_z_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [15:0] pitch_angle_o;
  logic [15:0] yaw_angle_o;

  direction_t pending_dirs [$];
  angles_t    angles_due [$];
  direction_t next_dir;
  angles_t    want;
  int         gap_cycles;
  int         requests_taken;
  int         request_total;
  int         mismatches;

  direction_to_pitch_yaw #(
    .COORD_BITS     (COORD_BITS),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .CORDIC_STEPS   (CORDIC_STEPS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .dir_x_i      (dir_x_i),
    .dir_y_i      (dir_y_i),
    .dir_z_i      (dir_z_i),
    .done_o       (done_o),
    .pitch_angle_o(pitch_angle_o),
    .yaw_angle_o  (yaw_angle_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic rotation_t vector_rotate(longint x, longint y, longint ang);
    rotation_t res;
    longint dx;
    longint dy;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        ang += ARCTAN_Q24[i];
      end else begin
        x -= dx;
        y += dy;
        ang -= ARCTAN_Q24[i];
      end
    end
    res.mag = x;
    res.ang = ang;
    return res;
  endfunction

  function automatic logic [15:0] round_degrees(longint ang);
    longint r;
    if (ang < 0) ang += 64'sd360 <<< ANGLE_Q;
    if (ang < 0) ang = 0;
    r = (ang + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
    while (r >= FULL_TURN) r -= FULL_TURN;
    return r[15:0];
  endfunction

  function automatic angles_t predict_angles(coord_t dx, coord_t dy, coord_t dz);
    angles_t res;
    rotation_t yaw_rot;
    rotation_t pitch_rot;
    longint x;
    longint y;
    longint start_ang;
    x = longint'(dx) * (64'sd1 <<< GUARD_SHIFT);
    y = longint'(dy) * (64'sd1 <<< GUARD_SHIFT);
    start_ang = 0;
    res.x = dx;
    res.y = dy;
    res.z = dz;
    if (dx == 0 && dy == 0) begin
      res.pitch = (dz > 0) ? PITCH_UP : PITCH_DOWN;
      res.yaw   = '0;
      return res;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      start_ang = 64'sd180 <<< ANGLE_Q;
    end
    yaw_rot   = vector_rotate(x, y, start_ang);
    pitch_rot = vector_rotate(yaw_rot.mag, (longint'(dz) * GAIN_Q30) >>> GAIN_SHIFT, 0);
    res.yaw   = round_degrees(yaw_rot.ang);
    res.pitch = round_degrees(pitch_rot.ang);
    return res;
  endfunction

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  function automatic coord_t pick_extreme();
    case ($urandom_range(0, 5))
      0: return C_MAX;
      1: return C_MIN;
      2: return '0;
      3: return coord_t'(1);
      4: return -coord_t'(1);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t pick_scaled();
    coord_t v;
    v = coord_t'($urandom);
    return v >>> $urandom_range(0, COORD_BITS - 1);
  endfunction

  function automatic direction_t random_direction();
    direction_t d;
    d.drain_first = 1'b0;
    d.x = coord_t'($urandom);
    d.y = coord_t'($urandom);
    d.z = coord_t'($urandom);
    case ($urandom_range(0, 9))
      5: begin
        d.x = coord_t'($urandom_range(0, 40)) - coord_t'(20);
        d.y = coord_t'($urandom_range(0, 40)) - coord_t'(20);
        d.z = coord_t'($urandom_range(0, 40)) - coord_t'(20);
      end
      6: begin
        d.x = '0;
        d.y = '0;
        if ($urandom_range(0, 1) == 0) d.z = pick_extreme();
      end
      7: begin
        if ($urandom_range(0, 1) == 0) d.y = coord_t'($urandom_range(0, 4)) - coord_t'(2);
        else d.x = coord_t'($urandom_range(0, 4)) - coord_t'(2);
      end
      8: begin
        d.x = pick_extreme();
        d.y = pick_extreme();
        d.z = pick_extreme();
      end
      9: begin
        d.x = pick_scaled();
        d.y = pick_scaled();
        d.z = pick_scaled();
      end
      default: ;
    endcase
    return d;
  endfunction

  task automatic add_direction(coord_t x, coord_t y, coord_t z);
    direction_t d;
    d.x = x;
    d.y = y;
    d.z = z;
    d.drain_first = 1'b0;
    pending_dirs.push_back(d);
  endtask

  task automatic note_mismatch(string what);
    if (mismatches < 10) $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Request driver: holds a request while busy, otherwise applies the next queued
  // direction after its idle gap. A flagged direction waits for every result.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && busy_o) begin
      start_i <= 1'b1;
    end else if (gap_cycles != 0) begin
      gap_cycles <= gap_cycles - 1;
      start_i <= 1'b0;
    end else if (pending_dirs.size() != 0 &&
                 !(pending_dirs[0].drain_first && (start_i || angles_due.size() != 0))) begin
      next_dir = pending_dirs.pop_front();
      dir_x_i <= next_dir.x;
      dir_y_i <= next_dir.y;
      dir_z_i <= next_dir.z;
      start_i <= 1'b1;
      gap_cycles <= next_gap();
    end else begin
      start_i <= 1'b0;
    end
  end

  // Result monitor: predicts each accepted request and checks each strobed result
  // against the oldest prediction still due.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        angles_due.push_back(predict_angles(dir_x_i, dir_y_i, dir_z_i));
        requests_taken++;
      end
      if (done_o) begin
        if (angles_due.size() == 0) begin
          note_mismatch($sformatf("result with no request due: pitch %0d yaw %0d",
                                  pitch_angle_o, yaw_angle_o));
        end else begin
          want = angles_due.pop_front();
          if (pitch_angle_o !== want.pitch)
            note_mismatch($sformatf("pitch for (%0d,%0d,%0d): expected %0d, got %0d",
                                    want.x, want.y, want.z, want.pitch, pitch_angle_o));
          if (yaw_angle_o !== want.yaw)
            note_mismatch($sformatf("yaw for (%0d,%0d,%0d): expected %0d, got %0d",
                                    want.x, want.y, want.z, want.yaw, yaw_angle_o));
        end
      end
    end
  end

  initial begin
    direction_t d;
    gap_cycles     = 0;
    requests_taken = 0;
    mismatches     = 0;

    add_direction('0, '0, '0);
    add_direction('0, '0, coord_t'(1));
    add_direction('0, '0, -coord_t'(1));
    add_direction('0, '0, C_MAX);
    add_direction('0, '0, C_MIN);
    add_direction(C_MAX, '0, '0);
    add_direction(C_MIN, '0, '0);
    add_direction('0, C_MAX, '0);
    add_direction('0, C_MIN, '0);
    add_direction(C_MAX, C_MAX, C_MAX);
    add_direction(C_MIN, C_MIN, C_MIN);
    add_direction(C_MAX, C_MIN, C_MAX);
    add_direction(C_MIN, C_MAX, C_MIN);
    add_direction(coord_t'(1), '0, '0);
    add_direction(-coord_t'(1), '0, '0);
    add_direction('0, coord_t'(1), '0);
    add_direction('0, -coord_t'(1), '0);
    add_direction(-coord_t'(1), -coord_t'(1), -coord_t'(1));
    add_direction(coord_t'(1), '0, coord_t'(1));
    add_direction(coord_t'(1), coord_t'(1), '0);
    add_direction(coord_t'(-5), '0, coord_t'(3));
    add_direction(coord_t'(3), coord_t'(-4), coord_t'(12));
    add_direction(coord_t'(1000000), -coord_t'(1), '0);
    add_direction(C_MIN, -coord_t'(1), C_MAX);

    for (int i = 0; i < 400; i++) begin
      d = random_direction();
      if (i == 0 || i == 150 || i == 300) d.drain_first = 1'b1;
      pending_dirs.push_back(d);
    end
    request_total = pending_dirs.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (requests_taken < request_total) @(posedge clk_i);
    while (angles_due.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule
